### rtl/ssipt_pkg.sv
// ssipt_pkg: widths, wrap thresholds, config indexes and stage types for the ssi encoder
// pole-pair tracker
// no dependencies
`timescale 1ns / 1ps

package ssipt_pkg;

    // fixed geometry of the 12-bit encoder
    localparam int PosW            = 12;
    localparam int PairW           = 8;
    localparam int CombW           = PosW + PairW;
    localparam int AngleW          = 19;
    localparam int ApcW            = 32;
    localparam int ProdW           = CombW + ApcW;
    localparam int AngleShift      = 16;
    localparam int CountsPerPair   = 4096;
    localparam int InDataW         = 24;
    localparam int OutFieldsW      = PosW + PairW + CombW + AngleW + 6;
    localparam int OutDataW        = ((OutFieldsW + 7) / 8) * 8;

    // wrap thresholds
    localparam logic [PosW-1:0] QuarterScale    = PosW'(CountsPerPair / 4);
    localparam logic [PosW-1:0] ThreeQuarter    = PosW'((CountsPerPair / 4) * 3);
    localparam logic [AngleW-1:0] AngleMax      = '1;

    // register indexes of the config port
    typedef enum logic
    {
        CFG_POLE_COUNT      = 1'b0,
        CFG_ANGLE_PER_COUNT = 1'b1
    } cfg_index_t;

    // decoded frame after the tracker stage
    typedef struct packed
    {
        logic [PosW-1:0]  position;
        logic [PairW-1:0] pair_index;
        logic [CombW-1:0] combined;
        logic             accepted;
        logic             ocf;
        logic             cof;
        logic             lin;
        logic             minc;
        logic             mdec;
    } trk_item_t;

endpackage

### rtl/ssi_encoder_pole_pair_tracker.sv
// ssi_encoder_pole_pair_tracker: unpacks a 3-byte ssi encoder frame, checks
// parity, tracks pole-pair wraps and scales the combined count to an angle
// depends on ssipt_pkg
`timescale 1ns / 1ps

// pipeline: input register, tracker stage, multiply stage; one item per cycle while
// m_tready is high, and a stalled receiver holds the pipeline
// the tracker state (last position, pair counter) updates as an item leaves the
// input register, so back-to-back frames see fresh state
// the angle multiply (20 x 32 bits) has a stage of its own
// reset: async active low; clears valids, tracker state, pole_count to 1 and
// angle_per_count to 0
module ssi_encoder_pole_pair_tracker
(
    input  logic                          clk,
    input  logic                          rst_n,
    // config write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [ssipt_pkg::ApcW-1:0]    cfg_data,
    // input frames
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // frame_byte_0 [7:0], frame_byte_1 [15:8], frame_byte_2 [23:16]
    input  logic [ssipt_pkg::InDataW-1:0] s_tdata,
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // position [11:0], pole_pair_index [19:12], combined_count [39:20],
    // angle_q16 [58:40], frame_accepted [59], offset_done [60],
    // cordic_overflow [61], linearity_alarm [62], field_increase [63],
    // field_decrease [64], zero [71:65]
    output logic [ssipt_pkg::OutDataW-1:0] m_tdata
);
    import ssipt_pkg::*;

    // config registers
    logic [PairW-1:0] pole_count_reg;
    logic [ApcW-1:0]  angle_per_count_reg;

    // tracker state
    logic [PosW-1:0]  last_pos_reg;
    logic [PairW-1:0] pair_cnt_reg;
    logic [PosW-1:0]  last_pos_next;
    logic [PairW-1:0] pair_cnt_next;

    // pipeline registers
    logic                 s1_valid_reg;
    logic [InDataW-1:0]   s1_data_reg;
    logic                 s2_valid_reg;
    trk_item_t            s2_reg;
    trk_item_t            s2_next;
    logic                 s3_valid_reg;
    trk_item_t            s3_reg;
    logic [AngleW-1:0]    angle_reg;
    logic [AngleW-1:0]    angle_next;

    // handshake between stages
    logic s3_ready;
    logic s2_ready;
    logic s1_ready;
    logic adv01;
    logic adv12;
    logic adv23;

    assign s3_ready  = !s3_valid_reg || m_tready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;
    assign cfg_ready = 1'b1;
    assign adv01     = s_tvalid && s1_ready;
    assign adv12     = s1_valid_reg && s2_ready;
    assign adv23     = s2_valid_reg && s3_ready;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_count_reg      <= PairW'(1);
            angle_per_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_POLE_COUNT:      pole_count_reg      <= cfg_data[PairW-1:0];
                CFG_ANGLE_PER_COUNT: angle_per_count_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (adv01)
        begin
            s1_data_reg <= s_tdata;
        end
    end

    // frame decode, parity check and pole-pair tracking
    logic [7:0]       b0;
    logic [7:0]       b1;
    logic [7:0]       b2;
    logic [PosW-1:0]  pos;
    logic             parity_ok;
    logic             accepted;
    logic [PosW-1:0]  raw;
    logic [PairW-1:0] poles;
    logic             wrap_up;
    logic             wrap_down;
    logic [PairW:0]   stepped;

    always_comb
    begin
        b0        = s1_data_reg[7:0];
        b1        = s1_data_reg[15:8];
        b2        = s1_data_reg[23:16];
        pos       = {b0[6:0], b1[7:3]};
        parity_ok = !(^{pos, b1[2:0], b2[7:5]});
        accepted  = parity_ok && b1[2] && !b1[1];
        raw       = accepted ? pos : last_pos_reg;
        poles     = (pole_count_reg == '0) ? PairW'(1) : pole_count_reg;
        wrap_up   = (raw < QuarterScale) && (last_pos_reg > ThreeQuarter);
        wrap_down = (raw > ThreeQuarter) && (last_pos_reg < QuarterScale);

        last_pos_next = last_pos_reg;
        pair_cnt_next = pair_cnt_reg;
        stepped       = {1'b0, pair_cnt_reg};
        if (raw != last_pos_reg)
        begin
            last_pos_next = raw;
            if (wrap_up)
            begin
                stepped = {1'b0, pair_cnt_reg} + (PairW+1)'(1);
            end
            else if (wrap_down)
            begin
                stepped = {1'b0, pair_cnt_reg} - (PairW+1)'(1);
            end
            // below zero wraps to the top, at or above the pole count to zero
            if (wrap_down && (pair_cnt_reg == '0))
            begin
                pair_cnt_next = poles - PairW'(1);
            end
            else if (stepped >= {1'b0, poles})
            begin
                pair_cnt_next = '0;
            end
            else
            begin
                pair_cnt_next = stepped[PairW-1:0];
            end
        end

        s2_next.position   = last_pos_next;
        s2_next.pair_index = pair_cnt_next;
        s2_next.combined   = {pair_cnt_next, last_pos_next};
        s2_next.accepted   = accepted;
        s2_next.ocf        = b1[2];
        s2_next.cof        = b1[1];
        s2_next.lin        = b1[0];
        s2_next.minc       = b2[7];
        s2_next.mdec       = b2[6];
    end

    // tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pos_reg <= '0;
            pair_cnt_reg <= '0;
        end
        else if (adv12)
        begin
            last_pos_reg <= last_pos_next;
            pair_cnt_reg <= pair_cnt_next;
        end
    end

    // tracker stage register
    always_ff @(posedge clk)
    begin
        if (adv12)
        begin
            s2_reg <= s2_next;
        end
    end

    // angle multiply with saturation
    logic [ProdW-1:0] product;

    always_comb
    begin
        product = ProdW'(s2_reg.combined) * ProdW'(angle_per_count_reg);
        if (|product[ProdW-1:AngleShift+AngleW])
        begin
            angle_next = AngleMax;
        end
        else
        begin
            angle_next = product[AngleShift+AngleW-1:AngleShift];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (adv23)
        begin
            s3_reg    <= s2_reg;
            angle_reg <= angle_next;
        end
    end

    // result packing
    assign m_tvalid = s3_valid_reg;
    assign m_tdata  = {(OutDataW - OutFieldsW)'(0),
                       s3_reg.mdec, s3_reg.minc, s3_reg.lin, s3_reg.cof,
                       s3_reg.ocf, s3_reg.accepted, angle_reg,
                       s3_reg.combined, s3_reg.pair_index, s3_reg.position};

    // a rejected frame leaves the pair counter alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv12 && !accepted) |=> $stable(pair_cnt_reg))
        else $error("pair counter moved on a rejected frame");

    // a rejected frame leaves the position alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv12 && !accepted) |=> $stable(last_pos_reg))
        else $error("position moved on a rejected frame");

    // combined count carries the position in its low bits
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_reg.combined[PosW-1:0] == s2_reg.position))
        else $error("combined count out of step with position");

    // a zero count gives a zero angle
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv23 && (s2_reg.combined == '0)) |=> (angle_reg == '0))
        else $error("angle nonzero for zero count");

    // an empty input register always takes an item
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_tready)
        else $error("input stalled with empty input register");

endmodule

### dv/testbench.sv
// testbench: self-checking bench for the ssi encoder pole-pair tracker, with a built-in
// frame tracker predicting every result item from the frames that go in
// depends on ssipt_pkg and ssi_encoder_pole_pair_tracker
`timescale 1ns / 1ps

module testbench;
    import ssipt_pkg::*;

    localparam int Latency        = 3;
    localparam int CycleLimit     = 200000;
    localparam int RandomPerPhase = 200;
    localparam int PhaseCount     = 7;
    localparam int MaxReports     = 10;

    // bit offsets of the result fields in m_tdata
    localparam int OffPair  = PosW;
    localparam int OffComb  = OffPair + PairW;
    localparam int OffAngle = OffComb + CombW;
    localparam int OffFlags = OffAngle + AngleW;

    typedef enum logic [1:0]
    {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN
    } sink_mode_t;

    typedef struct packed
    {
        logic [PosW-1:0]   position;
        logic [PairW-1:0]  pair_index;
        logic [CombW-1:0]  combined;
        logic [AngleW-1:0] angle;
        logic              accepted;
        logic              ocf;
        logic              cof;
        logic              lin;
        logic              minc;
        logic              mdec;
    } frame_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    cfg_index_t           cfg_index;
    logic [ApcW-1:0]      cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [InDataW-1:0]   s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OutDataW-1:0]  m_tdata;

    // tracker copy kept by the bench
    logic [PairW-1:0]     trk_pole_count;
    logic [ApcW-1:0]      trk_angle_step;
    logic [PosW-1:0]      trk_last_pos;
    logic [PairW-1:0]     trk_pair;

    frame_result_t        expected_results[$];
    frame_result_t        want;

    int                   errors = 0;
    int                   frames_sent = 0;
    int                   frames_accepted = 0;
    int                   pair_steps = 0;
    int                   results_seen = 0;
    int                   settings_used = 0;
    int                   cycles = 0;

    // stimulus pacing
    bit                   gaps_on = 1'b1;
    int                   burst_left = 0;
    sink_mode_t           sink_mode = READY_RANDOM;
    logic [10:0]          stall_pattern = 11'b10110011101;

    // random walk of the encoder shaft
    logic [PosW-1:0]      walk_pos = '0;
    int                   walk_dir = 1;

    ssi_encoder_pole_pair_tracker u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        // frame_byte_0, frame_byte_1, frame_byte_2
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        // position, pole_pair_index, combined_count, angle_q16, frame_accepted,
        // offset_done, cordic_overflow, linearity_alarm, field_increase, field_decrease
        .m_tdata   (m_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        case (sink_mode)
            READY_ALWAYS:
                m_tready <= 1'b1;
            READY_RANDOM:
                m_tready <= ($urandom_range(0, 99) >= 35);
            default:
            begin
                m_tready      <= stall_pattern[0];
                stall_pattern <= {stall_pattern[0], stall_pattern[10:1]};
            end
        endcase
    end

    // decode one frame and advance the tracker copy
    function automatic frame_result_t track_frame(input logic [InDataW-1:0] frame);
        logic [7:0]      b0;
        logic [7:0]      b1;
        logic [7:0]      b2;
        logic [PosW-1:0] pos;
        logic [PosW-1:0] raw;
        logic            par;
        int              c;
        int              poles;
        logic [63:0]     prod;
        frame_result_t   r;

        b0     = frame[7:0];
        b1     = frame[15:8];
        b2     = frame[23:16];
        pos    = {b0[6:0], b1[7:3]};
        r.ocf  = b1[2];
        r.cof  = b1[1];
        r.lin  = b1[0];
        r.minc = b2[7];
        r.mdec = b2[6];
        par    = b2[5];

        // even parity over position, flags and parity bit
        r.accepted = (((^pos) ^ r.ocf ^ r.cof ^ r.lin ^ r.minc ^ r.mdec ^ par) == 1'b0)
                     && r.ocf && !r.cof;
        raw = r.accepted ? pos : trk_last_pos;

        // pole-pair step on a wrap, then fold back into range
        if (raw != trk_last_pos)
        begin
            poles = (trk_pole_count == 0) ? 1 : int'(trk_pole_count);
            c     = int'(trk_pair);
            if (raw < QuarterScale && trk_last_pos > ThreeQuarter)
                c = c + 1;
            else if (raw > ThreeQuarter && trk_last_pos < QuarterScale)
                c = c - 1;
            if (c != int'(trk_pair))
                pair_steps++;
            trk_last_pos = raw;
            if (c < 0)
                c = poles - 1;
            else if (c >= poles)
                c = 0;
            trk_pair = PairW'(c);
        end

        r.position   = trk_last_pos;
        r.pair_index = trk_pair;
        r.combined   = {trk_pair, trk_last_pos};

        // scale to q3.16 radians with saturation
        prod    = 64'(r.combined) * 64'(trk_angle_step);
        prod    = prod >> AngleShift;
        r.angle = (prod > 64'(AngleMax)) ? AngleMax : prod[AngleW-1:0];
        return r;
    endfunction

    // build a frame, parity right unless asked otherwise; spare bits random
    function automatic logic [InDataW-1:0] make_frame(input logic [PosW-1:0] pos,
                                                      input logic ocf, input logic cof,
                                                      input logic lin, input logic minc,
                                                      input logic mdec,
                                                      input logic bad_parity);
        logic       par;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;

        par = (^pos) ^ ocf ^ cof ^ lin ^ minc ^ mdec ^ bad_parity;
        b0  = {1'($urandom), pos[11:5]};
        b1  = {pos[4:0], ocf, cof, lin};
        b2  = {minc, mdec, par, 5'($urandom)};
        return {b2, b1, b0};
    endfunction

    // mostly clean frames along a walking shaft, the rest noise and broken frames
    function automatic logic [InDataW-1:0] random_frame();
        int pick;
        int stride;

        if ($urandom_range(0, 19) == 0)
            walk_dir = -walk_dir;
        pick = $urandom_range(0, 99);
        if (pick < 78)
        begin
            stride = $urandom_range(0, 99);
            if (stride < 3)
            begin
                case ($urandom_range(0, 5))
                    0:       walk_pos = 12'd0;
                    1:       walk_pos = 12'd1023;
                    2:       walk_pos = 12'd1024;
                    3:       walk_pos = 12'd3072;
                    4:       walk_pos = 12'd3073;
                    default: walk_pos = 12'd4095;
                endcase
            end
            else if (stride < 88 && stride >= 13)
                walk_pos = walk_pos + PosW'(walk_dir * $urandom_range(1, 600));
            else if (stride >= 88)
                walk_pos = walk_pos + PosW'(walk_dir * $urandom_range(1024, 2047));
            return make_frame(walk_pos, 1'b1, 1'b0, 1'($urandom), 1'($urandom),
                              1'($urandom), 1'b0);
        end
        else if (pick < 84)
            return InDataW'($urandom);
        else if (pick < 90)
            return make_frame(walk_pos, 1'b1, 1'b0, 1'($urandom), 1'($urandom),
                              1'($urandom), 1'b1);
        else if (pick < 95)
            return make_frame(PosW'($urandom), 1'b0, 1'($urandom), 1'($urandom),
                              1'($urandom), 1'($urandom), 1'($urandom));
        else
            return make_frame(PosW'($urandom), 1'b1, 1'b1, 1'($urandom), 1'($urandom),
                              1'($urandom), 1'($urandom));
    endfunction

    // send one frame item, with burst gaps when enabled
    task automatic send_frame(input logic [InDataW-1:0] frame);
        frame_result_t predicted;

        if (gaps_on && burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= frame;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = track_frame(frame);
        expected_results.push_back(predicted);
        frames_sent++;
        if (predicted.accepted)
            frames_accepted++;
    endtask

    task automatic send_good(input logic [PosW-1:0] pos);
        send_frame(make_frame(pos, 1'b1, 1'b0, 1'($urandom), 1'($urandom),
                              1'($urandom), 1'b0));
    endtask

    // stop sending and let every pending result drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (Latency + 2) @(posedge clk);
    endtask

    // write both registers back to back, only while idle
    task automatic set_tracker_config(input logic [PairW-1:0] poles,
                                      input logic [ApcW-1:0] angle_step);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_POLE_COUNT;
        cfg_data  <= ApcW'(poles);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        trk_pole_count = poles;
        cfg_index <= CFG_ANGLE_PER_COUNT;
        cfg_data  <= angle_step;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        trk_angle_step = angle_step;
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic note_error(input string msg);
        errors++;
        if (errors <= MaxReports)
            $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (exp_val !== got_val)
            note_error($sformatf("%s expected %0d got %0d", name, exp_val, got_val));
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                note_error($sformatf("result item with no frame pending: %h", m_tdata));
            else
            begin
                want = expected_results.pop_front();
                check_field("position", 32'(want.position), 32'(m_tdata[0 +: PosW]));
                check_field("pole_pair_index", 32'(want.pair_index),
                            32'(m_tdata[OffPair +: PairW]));
                check_field("combined_count", 32'(want.combined),
                            32'(m_tdata[OffComb +: CombW]));
                check_field("angle_q16", 32'(want.angle), 32'(m_tdata[OffAngle +: AngleW]));
                check_field("frame_accepted", 32'(want.accepted), 32'(m_tdata[OffFlags]));
                check_field("offset_done", 32'(want.ocf), 32'(m_tdata[OffFlags + 1]));
                check_field("cordic_overflow", 32'(want.cof), 32'(m_tdata[OffFlags + 2]));
                check_field("linearity_alarm", 32'(want.lin), 32'(m_tdata[OffFlags + 3]));
                check_field("field_increase", 32'(want.minc), 32'(m_tdata[OffFlags + 4]));
                check_field("field_decrease", 32'(want.mdec), 32'(m_tdata[OffFlags + 5]));
            end
        end
    end

    // flag and field extremes under the reset register values
    task automatic test_frame_fields();
        send_frame(24'h000000);
        send_frame(24'hFFFFFF);
        send_frame(make_frame(12'hFFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        send_frame(make_frame(12'h000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        // same position again, no counter activity
        send_frame(make_frame(12'h000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
        // parity error
        send_frame(make_frame(12'h800, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        // offset compensation not finished
        send_frame(make_frame(12'h4D2, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        wait_idle();
    endtask

    // wraps both ways, exact quarter boundaries, saturated angle
    task automatic test_pole_wrap();
        logic [PosW-1:0] positions [0:8];

        positions = '{12'd3900, 12'd100, 12'd3900, 12'd200, 12'd3072,
                      12'd1024, 12'd3073, 12'd1023, 12'd4095};
        set_tracker_config(8'd3, 32'hFFFF_FFFF);
        foreach (positions[i])
            send_good(positions[i]);
        wait_idle();
    endtask

    // counter left above a lowered pole count, and a zero pole count
    task automatic test_pole_shrink();
        set_tracker_config(8'd3, 32'h0001_0000);
        send_good(12'd2000);
        send_good(12'd500);
        send_good(12'd3500);
        // cordic overflow frame is dropped
        send_frame(make_frame(12'd100, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        wait_idle();
        set_tracker_config(8'd2, 32'h0001_0000);
        send_good(12'd3400);
        wait_idle();
        set_tracker_config(8'd0, 32'h0001_0000);
        send_good(12'd100);
        send_good(12'd3800);
        wait_idle();
    endtask

    // random shaft motion over several register settings and pacing modes
    task automatic test_random_walk();
        logic [PairW-1:0] poles [0:PhaseCount-1];
        logic [ApcW-1:0]  steps [0:PhaseCount-1];
        bit               gaps  [0:PhaseCount-1];
        sink_mode_t       modes [0:PhaseCount-1];

        poles = '{8'd255, 8'd7, 8'd1, 8'd0, 8'd2, 8'd16, 8'd255};
        steps = '{32'd25837, 32'd941200, 32'd6588397, 32'd0, 32'hFFFF_FFFF,
                  32'd411774, 32'hFFFF_FFFF};
        steps[3] = $urandom;
        gaps  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        modes = '{READY_RANDOM, READY_ALWAYS, READY_PATTERN, READY_RANDOM,
                  READY_PATTERN, READY_ALWAYS, READY_RANDOM};
        for (int p = 0; p < PhaseCount; p++)
        begin
            set_tracker_config(poles[p], steps[p]);
            gaps_on   = gaps[p];
            sink_mode = modes[p];
            repeat (RandomPerPhase)
                send_frame(random_frame());
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_POLE_COUNT;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        trk_pole_count = 8'd1;
        trk_angle_step = '0;
        trk_last_pos   = '0;
        trk_pair       = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_frame_fields();
        test_pole_wrap();
        test_pole_shrink();
        test_random_walk();
        wait_idle();

        // anything still pending never came out
        if (expected_results.size() != 0)
        begin
            errors += expected_results.size();
            $display("%0d expected results never arrived", expected_results.size());
        end

        $display("covered %0d frames (%0d accepted, %0d pole-pair steps), %0d results checked",
                 frames_sent, frames_accepted, pair_steps, results_seen);
        $display("over %0d register settings with sender gaps and receiver stalls, %0d errors",
                 settings_used, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### ssi_encoder_pole_pair_tracker.f
rtl/ssipt_pkg.sv
rtl/ssi_encoder_pole_pair_tracker.sv
dv/testbench.sv
